@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL. They compile to nothing under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: invariant does not hold");

`define ASSERT_SAME(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed: same-cycle implication");

`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ASSERT_SAME(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

@@ hdl/cfa_pkg.sv @@
package cfa_pkg;

    localparam int HEADER_BYTES = 24;
    localparam int DATA_LIMIT   = 1048576;
    localparam int FRAME_DEPTH  = 64;

    localparam int PTR_W     = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
    localparam int FRAME_CAP = (FRAME_DEPTH > 127) ? 127 : FRAME_DEPTH;

    localparam logic [24:0] HEADER_W25     = 25'(HEADER_BYTES);
    localparam logic [23:0] DATA_LIMIT_W24 = 24'(DATA_LIMIT);
    localparam logic [6:0]  FRAME_CAP_W7   = 7'(FRAME_CAP);
    localparam logic [23:0] MAX24          = 24'hFF_FFFF;
    localparam logic [6:0]  MAX7           = 7'h7F;

    typedef logic [PTR_W-1:0] t_ptr;

    typedef enum logic [1:0] {
        REQ_SUBMIT  = 2'd0,
        REQ_SENT    = 2'd1,
        REQ_GRANT   = 2'd2,
        REQ_SUSPEND = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        STS_OK         = 3'd0,
        STS_TOO_LARGE  = 3'd1,
        STS_SUSPENDED  = 3'd2,
        STS_DISCARDED  = 3'd3,
        STS_RETRY      = 3'd4,
        STS_CREDIT_BAD = 3'd5,
        STS_EMPTY      = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        CFG_QUEUE_LIMIT = 2'd0,
        CFG_FRAME_LIMIT = 2'd1,
        CFG_REPLAY_MODE = 2'd2
    } t_cfg_index;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    function automatic t_ptr next_slot(input t_ptr ptr);
        return (ptr == t_ptr'(FRAME_DEPTH - 1)) ? t_ptr'(0) : t_ptr'(ptr + t_ptr'(1));
    endfunction

endpackage

@@ hdl/credit_frame_admission.sv @@
// Frame admission under byte and frame credit.
// Requests enter on the command channel: a word is taken at a rising edge with start
// high and busy low. i_req_type selects submit, sent, credit grant or suspend; the
// other input ports carry the operands for that request.
// The accept edge reads the frame-size FIFO memory at the head pointer, and in the
// following cycle (busy high) the request is applied to the counters and, for an
// admitted submit, the FIFO memory is written at the tail. A new request is not taken
// until the previous one has finished and busy has fallen.
// The result word appears as busy falls and stays for exactly one cycle, marked by
// o_result_valid. The receiver cannot stall it, and a new request may be taken at
// the edge that ends it. The *_now outputs show the counters after the request.
// Configuration is written through i_cfg_we, i_cfg_index and i_cfg_data while the
// block is idle; the user is bound to this and the block itself does not enforce it.
// A limit write also reloads the matching credit.
// Synchronous reset clears all counters, limits, flags and pointers. The FIFO memory
// is not cleared; an entry is used only after it has been written.
`include "assert_macros.svh"

module credit_frame_admission (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_req_type,
    input  logic [23:0] i_payload_length,
    input  logic        i_write_ok,
    input  logic [23:0] i_grant_bytes,
    input  logic [6:0]  i_grant_frames,
    input  logic        i_suspend_on,
    input  logic        i_flush_queue,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    output logic        o_result_valid,
    output logic [2:0]  o_status,
    output logic [31:0] o_frame_sequence,
    output logic [23:0] o_frame_bytes,
    output logic [23:0] o_queued_bytes_now,
    output logic [6:0]  o_queued_frames_now,
    output logic [23:0] o_byte_credit_now,
    output logic [6:0]  o_frame_credit_now,
    output logic [31:0] o_discard_total,
    output logic [23:0] o_peak_queued,
    output logic        o_link_failed
);
    import cfa_pkg::*;

    t_state r_state, n_state;

    logic [23:0] r_fifo_mem [FRAME_DEPTH];
    logic [23:0] r_rd_data;

    t_req        r_req;
    logic [23:0] r_plen;
    logic        r_wok;
    logic [23:0] r_gbytes;
    logic [6:0]  r_gframes;
    logic        r_son;
    logic        r_flush;

    logic [23:0] r_qlimit, n_qlimit;
    logic [6:0]  r_flimit, n_flimit;
    logic        r_replay, n_replay;
    logic [23:0] r_qbytes, n_qbytes;
    logic [6:0]  r_qframes, n_qframes;
    logic [23:0] r_bcredit, n_bcredit;
    logic [6:0]  r_fcredit, n_fcredit;
    logic [31:0] r_discard, n_discard;
    logic [31:0] r_seq, n_seq;
    logic [23:0] r_peak, n_peak;
    logic        r_susp, n_susp;
    logic        r_failed, n_failed;
    t_ptr        r_head, n_head;
    t_ptr        r_tail, n_tail;

    logic        r_valid;
    t_status     r_status, n_status;
    logic [31:0] r_seq_out, n_seq_out;
    logic [23:0] r_bytes_out, n_bytes_out;

    logic        w_accept;
    logic        w_mem_we;
    logic [24:0] w_size;
    logic [25:0] w_queue_sum;
    logic [24:0] w_credit_sum;
    logic [7:0]  w_frame_sum;
    logic [24:0] w_flush_bytes;
    logic [7:0]  w_flush_frames;
    logic [6:0]  w_cfg_frames;
    logic        w_too_large;
    logic        w_blocked;

    assign w_accept = start && (r_state == ST_IDLE);

    always_comb begin
        unique case (r_state)
            ST_IDLE: n_state = w_accept ? ST_EXEC : ST_IDLE;
            ST_EXEC: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        unique case (r_state)
            ST_IDLE: busy = 1'b0;
            ST_EXEC: busy = 1'b1;
            default: busy = 1'b0;
        endcase
    end

    assign w_size         = {1'b0, r_plen} + HEADER_W25;
    assign w_queue_sum    = {2'b00, r_qbytes} + {1'b0, w_size};
    assign w_credit_sum   = {1'b0, r_bcredit} + {1'b0, r_gbytes};
    assign w_frame_sum    = {1'b0, r_fcredit} + {1'b0, r_gframes};
    assign w_flush_bytes  = {1'b0, r_bcredit} + {1'b0, r_qbytes};
    assign w_flush_frames = {1'b0, r_fcredit} + {1'b0, r_qframes};
    assign w_cfg_frames   = (i_cfg_data[6:0] > FRAME_CAP_W7) ? FRAME_CAP_W7 : i_cfg_data[6:0];

    assign w_too_large = (r_plen > DATA_LIMIT_W24) || (w_size > {1'b0, r_qlimit});
    assign w_blocked   = (r_qframes >= r_flimit) || (w_queue_sum > {2'b00, r_qlimit}) ||
                         (r_fcredit == 7'd0) || (w_size > {1'b0, r_bcredit});

    always_comb begin
        n_qlimit    = r_qlimit;
        n_flimit    = r_flimit;
        n_replay    = r_replay;
        n_qbytes    = r_qbytes;
        n_qframes   = r_qframes;
        n_bcredit   = r_bcredit;
        n_fcredit   = r_fcredit;
        n_discard   = r_discard;
        n_seq       = r_seq;
        n_peak      = r_peak;
        n_susp      = r_susp;
        n_failed    = r_failed;
        n_head      = r_head;
        n_tail      = r_tail;
        n_status    = STS_OK;
        n_seq_out   = 32'd0;
        n_bytes_out = 24'd0;
        w_mem_we    = 1'b0;

        if (r_state == ST_EXEC) begin
            unique case (r_req)
                REQ_SUBMIT: begin
                    n_bytes_out = w_size[24] ? MAX24 : w_size[23:0];
                    if (w_too_large) begin
                        n_status = STS_TOO_LARGE;
                    end else if (r_susp) begin
                        n_status = STS_SUSPENDED;
                    end else if (w_blocked) begin
                        if (r_replay) begin
                            n_status = STS_RETRY;
                        end else begin
                            n_status  = STS_DISCARDED;
                            n_discard = r_discard + 32'd1;
                        end
                    end else begin
                        n_seq     = r_seq + 32'd1;
                        n_seq_out = r_seq + 32'd1;
                        w_mem_we  = 1'b1;
                        n_tail    = next_slot(r_tail);
                        n_qbytes  = w_queue_sum[23:0];
                        n_qframes = r_qframes + 7'd1;
                        n_bcredit = r_bcredit - w_size[23:0];
                        n_fcredit = r_fcredit - 7'd1;
                        if (w_queue_sum[23:0] > r_peak) begin
                            n_peak = w_queue_sum[23:0];
                        end
                    end
                end
                REQ_SENT: begin
                    if (r_qframes == 7'd0) begin
                        n_status = STS_EMPTY;
                    end else begin
                        n_bytes_out = r_rd_data;
                        n_head      = next_slot(r_head);
                        n_qbytes    = (r_rd_data > r_qbytes) ? 24'd0 : r_qbytes - r_rd_data;
                        n_qframes   = r_qframes - 7'd1;
                        if (!r_wok) begin
                            n_discard = r_discard + 32'd1;
                            n_failed  = 1'b1;
                            n_status  = STS_DISCARDED;
                        end
                    end
                end
                REQ_GRANT: begin
                    if ((r_gbytes != 24'd0) && (r_gframes != 7'd0) &&
                        (w_credit_sum <= {1'b0, r_qlimit}) &&
                        (w_frame_sum <= {1'b0, r_flimit})) begin
                        n_bcredit = w_credit_sum[23:0];
                        n_fcredit = w_frame_sum[6:0];
                    end else begin
                        n_status = STS_CREDIT_BAD;
                    end
                end
                REQ_SUSPEND: begin
                    n_susp = r_son;
                    if (r_flush) begin
                        n_bcredit = w_flush_bytes[24] ? MAX24 : w_flush_bytes[23:0];
                        n_fcredit = w_flush_frames[7] ? MAX7 : w_flush_frames[6:0];
                        n_discard = r_discard + 32'(r_qframes);
                        n_qbytes  = 24'd0;
                        n_qframes = 7'd0;
                        n_head    = r_tail;
                    end
                end
                default: begin
                    n_status = STS_OK;
                end
            endcase
        end

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_QUEUE_LIMIT: begin
                    n_qlimit  = i_cfg_data;
                    n_bcredit = i_cfg_data;
                end
                CFG_FRAME_LIMIT: begin
                    n_flimit  = w_cfg_frames;
                    n_fcredit = w_cfg_frames;
                end
                CFG_REPLAY_MODE: begin
                    n_replay = i_cfg_data[0];
                end
                default: begin
                    n_replay = r_replay;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_fifo_mem[r_tail] <= w_size[23:0];
        end
        if (w_accept) begin
            r_rd_data <= r_fifo_mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req     <= t_req'(i_req_type);
            r_plen    <= i_payload_length;
            r_wok     <= i_write_ok;
            r_gbytes  <= i_grant_bytes;
            r_gframes <= i_grant_frames;
            r_son     <= i_suspend_on;
            r_flush   <= i_flush_queue;
        end
        r_status    <= n_status;
        r_seq_out   <= n_seq_out;
        r_bytes_out <= n_bytes_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_valid   <= 1'b0;
            r_qlimit  <= 24'd0;
            r_flimit  <= 7'd0;
            r_replay  <= 1'b0;
            r_qbytes  <= 24'd0;
            r_qframes <= 7'd0;
            r_bcredit <= 24'd0;
            r_fcredit <= 7'd0;
            r_discard <= 32'd0;
            r_seq     <= 32'd0;
            r_peak    <= 24'd0;
            r_susp    <= 1'b0;
            r_failed  <= 1'b0;
            r_head    <= '0;
            r_tail    <= '0;
        end else begin
            r_state   <= n_state;
            r_valid   <= (r_state == ST_EXEC);
            r_qlimit  <= n_qlimit;
            r_flimit  <= n_flimit;
            r_replay  <= n_replay;
            r_qbytes  <= n_qbytes;
            r_qframes <= n_qframes;
            r_bcredit <= n_bcredit;
            r_fcredit <= n_fcredit;
            r_discard <= n_discard;
            r_seq     <= n_seq;
            r_peak    <= n_peak;
            r_susp    <= n_susp;
            r_failed  <= n_failed;
            r_head    <= n_head;
            r_tail    <= n_tail;
        end
    end

    assign o_result_valid      = r_valid;
    assign o_status            = r_status;
    assign o_frame_sequence    = r_seq_out;
    assign o_frame_bytes       = r_bytes_out;
    assign o_queued_bytes_now  = r_qbytes;
    assign o_queued_frames_now = r_qframes;
    assign o_byte_credit_now   = r_bcredit;
    assign o_frame_credit_now  = r_fcredit;
    assign o_discard_total     = r_discard;
    assign o_peak_queued       = r_peak;
    assign o_link_failed       = r_failed;

    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `ASSERT_NEXT(a_exec_result, i_clk, i_rst_n, busy, o_result_valid && !busy)
    `ASSERT_ALWAYS(a_queue_bound, i_clk, i_rst_n, r_qframes <= FRAME_CAP_W7)
    `ASSERT_NEXT(a_failed_sticky, i_clk, i_rst_n, r_failed, r_failed)
    `ASSERT_SAME(a_peak_covers, i_clk, i_rst_n, o_result_valid, r_peak >= r_qbytes)

endmodule
